// ----- hw/rtl/bbcl_pkg.sv -----
// ----------------------------------------------------------------------------
// bbcl_pkg
// Shared types and constants of the block buffer cache lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package bbcl_pkg;

  localparam int NUM_BUF    = 4;
  localparam int IDX_W      = 2;
  localparam int OFF_W      = 32;
  localparam int LEN_W      = 17;
  localparam int POS_W      = 16;
  localparam int SHIFT_W    = 5;
  localparam int SHIFT_MIN  = 4;
  localparam int SHIFT_MAX  = 16;
  localparam int SHIFT_RST  = 11;

  typedef enum logic [1:0] {
    CMD_LOOKUP    = 2'd0,
    CMD_FILL      = 2'd1,
    CMD_INV_SHORT = 2'd2,
    CMD_INV_ALL   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_MISS   = 3'd1,
    ST_BEYOND = 3'd2,
    ST_FAIL   = 3'd3,
    ST_BUSY   = 3'd4,
    ST_UNEXP  = 3'd5,
    ST_DONE   = 3'd6
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bbcl_in_if.sv -----
// ----------------------------------------------------------------------------
// bbcl_in_if
// Request channel: command word with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbcl_in_if
  import bbcl_pkg::*;
();
  logic              valid;
  logic              ready;
  cmd_t              cmd;
  logic [OFF_W-1:0]  byte_offset;
  logic [LEN_W-1:0]  fill_len;
  logic              fill_failed;

  modport source (output valid, cmd, byte_offset, fill_len, fill_failed, input ready);
  modport sink   (input valid, cmd, byte_offset, fill_len, fill_failed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bbcl_out_if.sv -----
// ----------------------------------------------------------------------------
// bbcl_out_if
// Result channel: lookup outcome word with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbcl_out_if
  import bbcl_pkg::*;
();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [IDX_W-1:0]  buffer_index;
  logic [OFF_W-1:0]  block_base;
  logic [POS_W-1:0]  offset_in_block;
  logic [LEN_W-1:0]  valid_length;

  modport source (output valid, status, buffer_index, block_base, offset_in_block,
                  valid_length, input ready);
  modport sink   (input valid, status, buffer_index, block_base, offset_in_block,
                  valid_length, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/block_buffer_cache_lookup.sv -----
// ----------------------------------------------------------------------------
// block_buffer_cache_lookup
// Tag controller of a four-buffer fully associative block cache, oldest-fill
// replacement.
//
//   channel   dir   handshake        word
//   in_ch     in    valid/ready      cmd, byte_offset, fill_len, fill_failed
//   out_ch    out   valid/ready      status, buffer_index, block_base,
//                                    offset_in_block, valid_length
//   cfg       in    cfg_we           cfg_wdata = block_shift
//
// Each word is first captured; then, in the execute step, all tags are compared in
// parallel, state is updated and the result register is loaded.
// The next word is taken while a result still waits in the result register;
// execution stalls only when that register is full and not being drained.
// Synchronous active-low reset: block shift 11, all buffers empty, no fetch.
// ----------------------------------------------------------------------------
`default_nettype none

module block_buffer_cache_lookup
  import bbcl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  bbcl_in_if.sink                  in_ch,
  bbcl_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [SHIFT_W-1:0]  cfg_wdata
);

  ctrl_cmd_t cmd;

  bbcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  bbcl_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_cmd              (in_ch.cmd),
    .in_byte_offset      (in_ch.byte_offset),
    .in_fill_len         (in_ch.fill_len),
    .in_fill_failed      (in_ch.fill_failed),
    .out_status          (out_ch.status),
    .out_buffer_index    (out_ch.buffer_index),
    .out_block_base      (out_ch.block_base),
    .out_offset_in_block (out_ch.offset_in_block),
    .out_valid_length    (out_ch.valid_length)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bbcl_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbcl_ctrl
// Sequencer: takes a word, runs its execute step, owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcl_ctrl
  import bbcl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output ctrl_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   exec_go;

  assign in_ready    = (state_r == S_IDLE);
  // result register is free or drains this cycle
  assign exec_go     = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = exec_go;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bbcl_dp.sv -----
// ----------------------------------------------------------------------------
// bbcl_dp
// Tag store, fill-age ranks, pending fetch and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcl_dp
  import bbcl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctrl_cmd_t           cmd,
  input  wire logic                cfg_we,
  input  wire logic [SHIFT_W-1:0]  cfg_wdata,
  input  wire cmd_t                in_cmd,
  input  wire logic [OFF_W-1:0]    in_byte_offset,
  input  wire logic [LEN_W-1:0]    in_fill_len,
  input  wire logic                in_fill_failed,
  output status_t                  out_status,
  output logic [IDX_W-1:0]         out_buffer_index,
  output logic [OFF_W-1:0]         out_block_base,
  output logic [POS_W-1:0]         out_offset_in_block,
  output logic [LEN_W-1:0]         out_valid_length
);

  // captured request word
  cmd_t             req_cmd_r;
  logic [OFF_W-1:0] req_off_r;
  logic [LEN_W-1:0] req_len_r;
  logic             req_failed_r;

  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [OFF_W-1:0]   tag_r   [NUM_BUF];
  logic [OFF_W-1:0]   tag_nxt [NUM_BUF];
  logic [LEN_W-1:0]   vlen_r   [NUM_BUF];
  logic [LEN_W-1:0]   vlen_nxt [NUM_BUF];
  logic [IDX_W-1:0]   rank_r   [NUM_BUF];
  logic [IDX_W-1:0]   rank_nxt [NUM_BUF];
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pvict_r, pvict_nxt;
  logic [OFF_W-1:0]   poff_r, poff_nxt;

  status_t          res_st_r, res_st_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [OFF_W-1:0] res_base_r, res_base_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic [LEN_W-1:0] res_len_r, res_len_nxt;

  logic [OFF_W-1:0] low_mask;
  logic [LEN_W-1:0] blk_size;
  logic [OFF_W-1:0] res_off;
  logic             res_zero;
  logic [OFF_W-1:0] req_base;
  logic [POS_W-1:0] req_pos;
  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] victim;
  logic [LEN_W-1:0] flen_clamp;
  logic [IDX_W-1:0] old_rank;
  logic [SHIFT_W-1:0] cfg_sat;

  assign low_mask = (OFF_W'(1) << shift_r) - OFF_W'(1);
  assign blk_size = LEN_W'(1) << shift_r;
  assign req_base = req_off_r & ~low_mask;
  assign req_pos  = POS_W'(req_off_r & low_mask);

  always_comb begin
    cfg_sat = cfg_wdata;
    if (cfg_wdata < SHIFT_W'(SHIFT_MIN)) begin
      cfg_sat = SHIFT_W'(SHIFT_MIN);
    end else if (cfg_wdata > SHIFT_W'(SHIFT_MAX)) begin
      cfg_sat = SHIFT_W'(SHIFT_MAX);
    end
  end

  // parallel tag compare, lowest index wins; oldest fill is the victim
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    victim  = '0;
    for (int i = NUM_BUF - 1; i >= 0; i--) begin
      if (vlen_r[i] != '0 && tag_r[i] == req_base) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (rank_r[i] == '0) begin
        victim = IDX_W'(i);
      end
    end
  end

  assign flen_clamp = (req_len_r > blk_size) ? blk_size : req_len_r;
  assign old_rank   = rank_r[pvict_r];

  always_comb begin
    shift_nxt   = shift_r;
    tag_nxt     = tag_r;
    vlen_nxt    = vlen_r;
    rank_nxt    = rank_r;
    pend_nxt    = pend_r;
    pvict_nxt   = pvict_r;
    poff_nxt    = poff_r;
    res_st_nxt  = res_st_r;
    res_idx_nxt = res_idx_r;
    res_len_nxt = res_len_r;
    res_off     = req_off_r;
    res_zero    = 1'b0;

    if (cmd.exec) begin
      case (req_cmd_r)
        CMD_LOOKUP: begin
          if (pend_r) begin
            res_st_nxt  = ST_BUSY;
            res_idx_nxt = pvict_r;
            res_off     = poff_r;
            res_len_nxt = vlen_r[pvict_r];
          end else if (hit_any) begin
            res_st_nxt  = (LEN_W'(req_pos) < vlen_r[hit_idx]) ? ST_HIT : ST_BEYOND;
            res_idx_nxt = hit_idx;
            res_len_nxt = vlen_r[hit_idx];
          end else begin
            res_st_nxt  = ST_MISS;
            res_idx_nxt = victim;
            res_len_nxt = vlen_r[victim];
            pend_nxt    = 1'b1;
            pvict_nxt   = victim;
            poff_nxt    = req_off_r;
          end
        end
        CMD_FILL: begin
          if (!pend_r) begin
            res_st_nxt = ST_UNEXP;
            res_zero   = 1'b1;
          end else begin
            pend_nxt    = 1'b0;
            res_idx_nxt = pvict_r;
            res_off     = poff_r;
            if (req_failed_r) begin
              res_st_nxt  = ST_FAIL;
              res_len_nxt = vlen_r[pvict_r];
            end else begin
              tag_nxt[pvict_r]  = poff_r & ~low_mask;
              vlen_nxt[pvict_r] = flen_clamp;
              for (int i = 0; i < NUM_BUF; i++) begin
                if (rank_r[i] > old_rank) begin
                  rank_nxt[i] = rank_r[i] - IDX_W'(1);
                end
              end
              rank_nxt[pvict_r] = IDX_W'(NUM_BUF - 1);
              res_st_nxt  = (LEN_W'(poff_r & low_mask) < flen_clamp) ? ST_HIT : ST_BEYOND;
              res_len_nxt = flen_clamp;
            end
          end
        end
        CMD_INV_SHORT: begin
          for (int i = 0; i < NUM_BUF; i++) begin
            if (vlen_r[i] < blk_size) begin
              vlen_nxt[i] = '0;
            end
          end
          res_st_nxt = ST_DONE;
          res_zero   = 1'b1;
        end
        default: begin
          for (int i = 0; i < NUM_BUF; i++) begin
            vlen_nxt[i] = '0;
          end
          res_st_nxt = ST_DONE;
          res_zero   = 1'b1;
        end
      endcase
    end

    if (res_zero) begin
      res_idx_nxt  = '0;
      res_len_nxt  = '0;
      res_base_nxt = '0;
      res_pos_nxt  = '0;
    end else begin
      res_base_nxt = res_off & ~low_mask;
      res_pos_nxt  = POS_W'(res_off & low_mask);
    end
    if (!cmd.exec) begin
      res_base_nxt = res_base_r;
      res_pos_nxt  = res_pos_r;
    end

    // any block size write empties every buffer and drops the pending fetch
    if (cfg_we) begin
      shift_nxt = cfg_sat;
      pend_nxt  = 1'b0;
      for (int i = 0; i < NUM_BUF; i++) begin
        vlen_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_W'(SHIFT_RST);
      pend_r  <= 1'b0;
      for (int i = 0; i < NUM_BUF; i++) begin
        vlen_r[i] <= '0;
        rank_r[i] <= IDX_W'(i);
      end
    end else begin
      shift_r <= shift_nxt;
      pend_r  <= pend_nxt;
      vlen_r  <= vlen_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r      <= tag_nxt;
    pvict_r    <= pvict_nxt;
    poff_r     <= poff_nxt;
    res_st_r   <= res_st_nxt;
    res_idx_r  <= res_idx_nxt;
    res_base_r <= res_base_nxt;
    res_pos_r  <= res_pos_nxt;
    res_len_r  <= res_len_nxt;
    if (cmd.capture) begin
      req_cmd_r    <= in_cmd;
      req_off_r    <= in_byte_offset;
      req_len_r    <= in_fill_len;
      req_failed_r <= in_fill_failed;
    end
  end

  assign out_status          = res_st_r;
  assign out_buffer_index    = res_idx_r;
  assign out_block_base      = res_base_r;
  assign out_offset_in_block = res_pos_r;
  assign out_valid_length    = res_len_r;

endmodule

`default_nettype wire
